### rtl/absub_pkg.sv
// Shared types and constants of the averaging background subtractor.
// No dependencies; every other file in rtl/ imports this package.
package absub_pkg;

   localparam int PIX_AW    = 16;             // pixel address width
   localparam int PIXELS    = 1 << PIX_AW;    // entries per store
   localparam int CHANS     = 3;
   localparam int PIX_W     = 8;
   localparam int SUM_W     = 16;
   localparam int CNT_W     = 8;
   localparam int SCALE_W   = 4;
   localparam int PROD_W    = PIX_W + SCALE_W;
   localparam int LANES     = 2 * CHANS;      // channel sums, then difference sums
   localparam int DIV_STEPS = 2;              // quotient bits per divider stage

   localparam int CSR_AW = 2;
   localparam int CSR_DW = 8;
   localparam logic [CSR_AW-1:0] CSR_ACCUM_COUNT = 2'd0;
   localparam logic [CSR_AW-1:0] CSR_HIGH_SCALE  = 2'd1;
   localparam logic [CSR_AW-1:0] CSR_LOW_SCALE   = 2'd2;

   localparam logic [CNT_W-1:0]   ACCUM_COUNT_RST = 8'd27;
   localparam logic [SCALE_W-1:0] HIGH_SCALE_RST  = 4'd7;
   localparam logic [SCALE_W-1:0] LOW_SCALE_RST   = 4'd6;

   typedef enum logic [1:0] {
      KIND_SET_PREV = 2'd0,
      KIND_ACCUM    = 2'd1,
      KIND_BUILD    = 2'd2,
      KIND_DETECT   = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type            kind;
      logic [PIX_AW-1:0]   pixel_index;
      logic [PIX_W-1:0]    chan0;
      logic [PIX_W-1:0]    chan1;
      logic [PIX_W-1:0]    chan2;
   } req_type;

   typedef struct packed {
      logic foreground;
      logic mask_valid;
   } rsp_type;

   typedef logic [CHANS-1:0][PIX_W-1:0] pix3_type;

   typedef struct packed {
      logic [CHANS-1:0][SUM_W-1:0] csum;
      logic [CHANS-1:0][SUM_W-1:0] dsum;
      pix3_type                    prev;
   } hist_type;

   typedef struct packed {
      pix3_type lo;
      pix3_type hi;
   } bnd_type;

   typedef struct packed {
      logic [SUM_W-1:0] rem;
      logic [PIX_W-1:0] quo;
      logic             sat;
   } div_type;

   typedef struct packed {
      logic              valid;
      kind_type          kind;
      logic [PIX_AW-1:0] index;
      pix3_type          pix;
   } item_type;

   typedef struct packed {
      item_type                 item;
      div_type [LANES-1:0]      lane;
   } pipe_type;

   typedef struct packed {
      logic              active;
      logic [PIX_AW-1:0] addr;
   } clr_type;

   typedef struct packed {
      logic    ld_p1;
      logic    ld_p2;
      clr_type clr;
   } hist_ctl_type;

   typedef struct packed {
      logic    ld_p7;
      logic    ld_p8;
      logic    ld_p9;
      clr_type clr;
   } bnd_ctl_type;

   typedef struct packed {
      logic p7_valid;
      logic p8_valid;
   } bnd_sts_type;

endpackage

### rtl/averaging_background_subtractor_unit.sv
// Averaging background subtractor: per-pixel learning and foreground detection.
// Channels: req_ (one pixel item, valid/ready), rsp_ (one result per item,
// valid/ready) and csr_ (register writes: 0 accum_count, 1 high_scale,
// 2 low_scale; other indexes are ignored; csr_ready is always high).
// Registers are to be written by the user only while the pipeline is empty;
// the block itself does not enforce this. Throughput: one item per cycle
// unless rsp_ready stalls, set by the single-port read/modify/write of the
// history and bounds stores with forwarding from the next stage. Between the
// req_ transfer and rsp_valid lie two history stages, four divider stages
// at two quotient bits each, bound math, bounds lookup and compare, and the
// result register. Reset: configuration returns to 27/7/6 and a clearing pass
// zeroes all 65536 entries of both stores, one per cycle; req_ready stays low
// until the pass ends. csr_ writes are taken during the pass.
// Stall: valid bits travel with each stage; when rsp_ready is low, bubbles
// still close up, so items are taken until all nine stages are full.
// Depends on absub_pkg, absub_hist, absub_div and absub_bnd.
module averaging_background_subtractor_unit
   import absub_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CSR_AW-1:0] csr_index,
   input  logic [CSR_DW-1:0] csr_data
);

   logic [CNT_W-1:0]   accum_count_ff;
   logic [SCALE_W-1:0] high_scale_ff;
   logic [SCALE_W-1:0] low_scale_ff;
   logic [PIX_AW:0]    clr_cnt_ff;
   clr_type            clr;
   logic               req_take;

   hist_ctl_type hist_ctl;
   bnd_ctl_type  bnd_ctl;
   bnd_sts_type  bnd_sts;
   logic         p1_valid;
   pipe_type     p2, p3, p4, p5, p6;
   logic         ld1, ld2, ld3, ld4, ld5, ld6, ld7, ld8, ld9;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         accum_count_ff <= ACCUM_COUNT_RST;
         high_scale_ff  <= HIGH_SCALE_RST;
         low_scale_ff   <= LOW_SCALE_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACCUM_COUNT: accum_count_ff <= csr_data[CNT_W-1:0];
            CSR_HIGH_SCALE:  high_scale_ff  <= csr_data[SCALE_W-1:0];
            CSR_LOW_SCALE:   low_scale_ff   <= csr_data[SCALE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clearing pass: top bit of the counter marks the pass done.
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (!clr_cnt_ff[PIX_AW]) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   assign clr.active = !clr_cnt_ff[PIX_AW];
   assign clr.addr   = clr_cnt_ff[PIX_AW-1:0];

   // A stage loads when it is empty or its contents move on.
   assign ld9 = !rsp_valid || rsp_ready;
   assign ld8 = !bnd_sts.p8_valid || ld9;
   assign ld7 = !bnd_sts.p7_valid || ld8;
   assign ld6 = !p6.item.valid || ld7;
   assign ld5 = !p5.item.valid || ld6;
   assign ld4 = !p4.item.valid || ld5;
   assign ld3 = !p3.item.valid || ld4;
   assign ld2 = !p2.item.valid || ld3;
   assign ld1 = !p1_valid || ld2;

   assign req_ready = ld1 && !clr.active;
   assign req_take  = req_valid && req_ready;

   assign hist_ctl.ld_p1 = ld1;
   assign hist_ctl.ld_p2 = ld2;
   assign hist_ctl.clr   = clr;
   assign bnd_ctl.ld_p7  = ld7;
   assign bnd_ctl.ld_p8  = ld8;
   assign bnd_ctl.ld_p9  = ld9;
   assign bnd_ctl.clr    = clr;

   absub_hist u_hist (
      .clock       (clock),
      .reset       (reset),
      .ctl         (hist_ctl),
      .req_take    (req_take),
      .req_data    (req_data),
      .accum_count (accum_count_ff),
      .p1_valid    (p1_valid),
      .p2          (p2)
   );

   absub_div u_div3 (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld3),
      .accum_count (accum_count_ff),
      .up_stage    (p2),
      .down_stage  (p3)
   );

   absub_div u_div4 (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld4),
      .accum_count (accum_count_ff),
      .up_stage    (p3),
      .down_stage  (p4)
   );

   absub_div u_div5 (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld5),
      .accum_count (accum_count_ff),
      .up_stage    (p4),
      .down_stage  (p5)
   );

   absub_div u_div6 (
      .clock       (clock),
      .reset       (reset),
      .ld          (ld6),
      .accum_count (accum_count_ff),
      .up_stage    (p5),
      .down_stage  (p6)
   );

   absub_bnd u_bnd (
      .clock      (clock),
      .reset      (reset),
      .ctl        (bnd_ctl),
      .p6         (p6),
      .high_scale (high_scale_ff),
      .low_scale  (low_scale_ff),
      .sts        (bnd_sts),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data)
   );

   a_clr_empty: assert property (@(posedge clock) disable iff (reset)
      clr.active |-> !(p1_valid || p2.item.valid || p3.item.valid || p4.item.valid ||
                       p5.item.valid || p6.item.valid || bnd_sts.p7_valid ||
                       bnd_sts.p8_valid || rsp_valid))
      else $error("pipeline holds an item during the clearing pass");

   a_clr_done: assert property (@(posedge clock) disable iff (reset)
      !clr.active |=> !clr.active)
      else $error("clearing pass restarted without reset");

   a_take_lands: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> p1_valid)
      else $error("accepted transfer did not reach the first stage");

   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready && p1_valid && p2.item.valid && p3.item.valid &&
       p4.item.valid && p5.item.valid && p6.item.valid && bnd_sts.p7_valid &&
       bnd_sts.p8_valid) |-> !req_ready)
      else $error("transfer taken while every stage is full and stalled");

endmodule

### rtl/absub_hist.sv
// Front end: per-pixel history store (sums and previous pixel), update and
// divider setup. Depends on absub_pkg.
module absub_hist
   import absub_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  hist_ctl_type     ctl,
   input  logic             req_take,
   input  req_type          req_data,
   input  logic [CNT_W-1:0] accum_count,
   output logic             p1_valid,
   output pipe_type         p2
);

   item_type p1_ff, p1_in;
   hist_type hist_mem_ff [PIXELS];
   hist_type rd_hist_ff;
   hist_type cur_hist, new_hist;
   hist_type p2_hist_ff;
   logic     p2_wr_ff;
   logic     p1_wr;
   pipe_type p2_ff, p2_in;

   logic [CHANS-1:0][SUM_W:0] csum_s;
   logic [CHANS-1:0][SUM_W:0] dsum_s;
   logic [CHANS-1:0][PIX_W-1:0] adiff;

   // Rounded-division setup: numerator = sum + div/2, saturation flagged up front.
   function automatic div_type init_lane(logic [SUM_W-1:0] sum, logic [CNT_W-1:0] d);
      logic [SUM_W:0] num;
      logic [SUM_W:0] lim;
      div_type        r;
      num   = {1'b0, sum} + {{(SUM_W + 2 - CNT_W){1'b0}}, d[CNT_W-1:1]};
      lim   = {1'b0, d, {PIX_W{1'b0}}};
      r.rem = num[SUM_W-1:0];
      r.quo = '0;
      r.sat = (d == '0) ? (num != '0) : (num >= lim);
      return r;
   endfunction

   always_comb begin
      p1_in.valid = req_take;
      p1_in.kind  = req_data.kind;
      p1_in.index = req_data.pixel_index;
      p1_in.pix   = {req_data.chan2, req_data.chan1, req_data.chan0};
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_p1) begin
         p1_ff <= p1_in;
      end
      if (reset) begin
         p1_ff.valid <= 1'b0;
      end
   end

   assign p1_wr = p1_ff.valid && (p1_ff.kind == KIND_SET_PREV || p1_ff.kind == KIND_ACCUM);

   // Write happens on the edge the item leaves p1; a read on that edge sees old data,
   // so the one item in p2 is the only one that can be newer than the memory.
   always_ff @(posedge clock) begin
      if (ctl.clr.active) begin
         hist_mem_ff[ctl.clr.addr] <= '0;
      end else if (p1_wr && ctl.ld_p2) begin
         hist_mem_ff[p1_ff.index] <= new_hist;
      end
      if (ctl.ld_p1) begin
         rd_hist_ff <= hist_mem_ff[req_data.pixel_index];
      end
   end

   assign cur_hist = (p2_wr_ff && p2_ff.item.index == p1_ff.index) ? p2_hist_ff : rd_hist_ff;

   always_comb begin
      new_hist = cur_hist;
      for (int c = 0; c < CHANS; c++) begin
         adiff[c]  = (p1_ff.pix[c] > cur_hist.prev[c]) ? p1_ff.pix[c] - cur_hist.prev[c]
                                                       : cur_hist.prev[c] - p1_ff.pix[c];
         csum_s[c] = {1'b0, cur_hist.csum[c]} + {{(SUM_W + 1 - PIX_W){1'b0}}, p1_ff.pix[c]};
         dsum_s[c] = {1'b0, cur_hist.dsum[c]} + {{(SUM_W + 1 - PIX_W){1'b0}}, adiff[c]};
      end
      case (p1_ff.kind)
         KIND_SET_PREV: begin
            new_hist.prev = p1_ff.pix;
         end
         KIND_ACCUM: begin
            for (int c = 0; c < CHANS; c++) begin
               new_hist.csum[c] = csum_s[c][SUM_W] ? '1 : csum_s[c][SUM_W-1:0];
               new_hist.dsum[c] = dsum_s[c][SUM_W] ? '1 : dsum_s[c][SUM_W-1:0];
            end
            new_hist.prev = p1_ff.pix;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      p2_in.item = p1_ff;
      for (int c = 0; c < CHANS; c++) begin
         p2_in.lane[c]         = init_lane(cur_hist.csum[c], accum_count);
         p2_in.lane[CHANS + c] = init_lane(cur_hist.dsum[c], accum_count);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_p2) begin
         p2_ff      <= p2_in;
         p2_hist_ff <= new_hist;
         p2_wr_ff   <= p1_wr;
      end
      if (reset) begin
         p2_ff.item.valid <= 1'b0;
         p2_wr_ff         <= 1'b0;
      end
   end

   assign p1_valid = p1_ff.valid;
   assign p2       = p2_ff;

endmodule

### rtl/absub_div.sv
// One divider stage: two restoring quotient steps on all six lanes.
// Depends on absub_pkg.
module absub_div
   import absub_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             ld,
   input  logic [CNT_W-1:0] accum_count,
   input  pipe_type         up_stage,
   output pipe_type         down_stage
);

   pipe_type stage_ff, stage_in;

   // Remainder stays below div*256; doubling it and comparing with div*256
   // yields the next quotient bit, MSB first.
   function automatic div_type div_step(div_type l, logic [CNT_W-1:0] d);
      logic [SUM_W:0] twice;
      logic [SUM_W:0] dsh;
      logic [SUM_W:0] diffv;
      logic           take;
      div_type        r;
      twice = {l.rem, 1'b0};
      dsh   = {1'b0, d, {PIX_W{1'b0}}};
      diffv = twice - dsh;
      take  = (d != '0) && (twice >= dsh);
      r     = l;
      r.rem = take ? diffv[SUM_W-1:0] : twice[SUM_W-1:0];
      r.quo = {l.quo[PIX_W-2:0], take};
      return r;
   endfunction

   always_comb begin
      stage_in = up_stage;
      for (int l = 0; l < LANES; l++) begin
         for (int s = 0; s < DIV_STEPS; s++) begin
            stage_in.lane[l] = div_step(stage_in.lane[l], accum_count);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ld) begin
         stage_ff <= stage_in;
      end
      if (reset) begin
         stage_ff.item.valid <= 1'b0;
      end
   end

   assign down_stage = stage_ff;

endmodule

### rtl/absub_bnd.sv
// Back end: bound computation, bounds store, detect compare and result register.
// Depends on absub_pkg.
module absub_bnd
   import absub_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  bnd_ctl_type        ctl,
   input  pipe_type           p6,
   input  logic [SCALE_W-1:0] high_scale,
   input  logic [SCALE_W-1:0] low_scale,
   output bnd_sts_type        sts,
   output logic               rsp_valid,
   output rsp_type            rsp_data
);

   typedef struct packed {
      item_type                     item;
      pix3_type                     avg;
      logic [CHANS-1:0][PROD_W-1:0] hprod;
      logic [CHANS-1:0][PROD_W-1:0] lprod;
   } p7_type;

   typedef struct packed {
      item_type item;
      bnd_type  bnd;
   } p8_type;

   p7_type   p7_ff, p7_in;
   p8_type   p8_ff, p8_in;
   bnd_type  bnd_mem_ff [PIXELS];
   bnd_type  rd_bnd_ff;
   bnd_type  cur_bnd;
   logic     bnd_wr;
   logic     in_bnd;
   rsp_type  rsp_in;
   logic     rsp_valid_ff;
   rsp_type  rsp_data_ff;
   logic     p9_build_ff;
   logic [PIX_AW-1:0] p9_index_ff;
   bnd_type  p9_bnd_ff;

   pix3_type dv, dv1;
   logic [CHANS-1:0][PROD_W:0] hsum;

   // Quotients out of the divider, diff + 1, then the two scale products.
   always_comb begin
      p7_in.item = p6.item;
      for (int c = 0; c < CHANS; c++) begin
         p7_in.avg[c]   = p6.lane[c].sat ? '1 : p6.lane[c].quo;
         dv[c]          = p6.lane[CHANS + c].sat ? '1 : p6.lane[CHANS + c].quo;
         dv1[c]         = (dv[c] == '1) ? dv[c] : dv[c] + 1'b1;
         p7_in.hprod[c] = {{PIX_W{1'b0}}, high_scale} * {{SCALE_W{1'b0}}, dv1[c]};
         p7_in.lprod[c] = {{PIX_W{1'b0}}, low_scale} * {{SCALE_W{1'b0}}, dv1[c]};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_p7) begin
         p7_ff <= p7_in;
      end
      if (reset) begin
         p7_ff.item.valid <= 1'b0;
      end
   end

   always_comb begin
      p8_in.item = p7_ff.item;
      for (int c = 0; c < CHANS; c++) begin
         hsum[c] = {{(PROD_W + 1 - PIX_W){1'b0}}, p7_ff.avg[c]} + {1'b0, p7_ff.hprod[c]};
         p8_in.bnd.hi[c] = (hsum[c][PROD_W:PIX_W] != '0) ? '1 : hsum[c][PIX_W-1:0];
         p8_in.bnd.lo[c] = (p7_ff.lprod[c] > {{SCALE_W{1'b0}}, p7_ff.avg[c]}) ? '0
                           : p7_ff.avg[c] - p7_ff.lprod[c][PIX_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_p8) begin
         p8_ff <= p8_in;
      end
      if (reset) begin
         p8_ff.item.valid <= 1'b0;
      end
   end

   assign bnd_wr = p8_ff.item.valid && p8_ff.item.kind == KIND_BUILD && ctl.ld_p9;

   // Read is issued as the item enters p8; a build leaving p8 on that same edge
   // sits in p9 afterward and is forwarded from there.
   always_ff @(posedge clock) begin
      if (ctl.clr.active) begin
         bnd_mem_ff[ctl.clr.addr] <= '0;
      end else if (bnd_wr) begin
         bnd_mem_ff[p8_ff.item.index] <= p8_ff.bnd;
      end
      if (ctl.ld_p8) begin
         rd_bnd_ff <= bnd_mem_ff[p7_ff.item.index];
      end
   end

   assign cur_bnd = (p9_build_ff && p9_index_ff == p8_ff.item.index) ? p9_bnd_ff : rd_bnd_ff;

   always_comb begin
      in_bnd = 1'b0;
      for (int c = 0; c < CHANS; c++) begin
         if (p8_ff.item.pix[c] >= cur_bnd.lo[c] && p8_ff.item.pix[c] <= cur_bnd.hi[c]) begin
            in_bnd = 1'b1;
         end
      end
      rsp_in.mask_valid = (p8_ff.item.kind == KIND_DETECT);
      rsp_in.foreground = (p8_ff.item.kind == KIND_DETECT) && !in_bnd;
   end

   always_ff @(posedge clock) begin
      if (ctl.ld_p9) begin
         rsp_valid_ff <= p8_ff.item.valid;
         rsp_data_ff  <= rsp_in;
         p9_build_ff  <= p8_ff.item.valid && p8_ff.item.kind == KIND_BUILD;
         p9_index_ff  <= p8_ff.item.index;
         p9_bnd_ff    <= p8_ff.bnd;
      end
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         p9_build_ff  <= 1'b0;
      end
   end

   assign sts.p7_valid = p7_ff.item.valid;
   assign sts.p8_valid = p8_ff.item.valid;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data     = rsp_data_ff;

endmodule

### dv/tb_averaging_background_subtractor_unit.sv
// Testbench for averaging_background_subtractor_unit: random learn/detect traffic
// checked against an in-bench per-pixel model. Depends on absub_pkg and the RTL.
`timescale 1ns / 100ps
module tb_averaging_background_subtractor_unit;
   import absub_pkg::*;

   localparam int QUIET_LIMIT = 200000;  // outlasts the clearing pass
   localparam int HOLD_CYCLES = 300;
   localparam int HOLD_AFTER  = 600;     // responses seen before the long hold-off

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_data = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_data;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CSR_AW-1:0] csr_index = '0;
   logic [CSR_DW-1:0] csr_data = '0;

   averaging_background_subtractor_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #2 clock = ~clock;

   // pixel model state
   bit [SUM_W-1:0]   chan_sum  [PIXELS][CHANS];
   bit [SUM_W-1:0]   diff_sum  [PIXELS][CHANS];
   bit [PIX_W-1:0]   prev_pix  [PIXELS][CHANS];
   bit [PIX_W-1:0]   low_bnd   [PIXELS][CHANS];
   bit [PIX_W-1:0]   high_bnd  [PIXELS][CHANS];
   logic [CNT_W-1:0]   div_count;
   logic [SCALE_W-1:0] high_mult;
   logic [SCALE_W-1:0] low_mult;

   req_type       pixel_queue [$];
   rsp_type       expected_mask [$];
   int            fail_count = 0;
   int            rsp_count = 0;
   logic [15:0]   spots [10];

   function automatic logic [7:0] round_quot(input logic [SUM_W-1:0] total,
                                             input logic [CNT_W-1:0] divisor);
      int q;
      if (divisor == 0)
         return (total != 0) ? 8'hFF : 8'h00;
      q = (int'(total) + int'(divisor) / 2) / int'(divisor);
      return (q > 255) ? 8'hFF : q[7:0];
   endfunction

   // applies one pixel to the model and returns its mask result
   function automatic rsp_type update_pixel(input req_type r);
      rsp_type       o;
      logic [7:0]    px [CHANS];
      int unsigned   i, avg, dif, up, dn, d, tot;
      int            c;
      bit            in_bnd;
      i = r.pixel_index;
      px[0] = r.chan0;
      px[1] = r.chan1;
      px[2] = r.chan2;
      in_bnd = 1'b0;
      o.foreground = 1'b0;
      o.mask_valid = (r.kind == KIND_DETECT);
      for (c = 0; c < CHANS; c++) begin
         case (r.kind)
            KIND_SET_PREV: begin
               prev_pix[i][c] = px[c];
            end
            KIND_ACCUM: begin
               d = (px[c] > prev_pix[i][c]) ? px[c] - prev_pix[i][c] : prev_pix[i][c] - px[c];
               tot = chan_sum[i][c] + px[c];
               chan_sum[i][c] = (tot > 65535) ? 16'hFFFF : tot[15:0];
               tot = diff_sum[i][c] + d;
               diff_sum[i][c] = (tot > 65535) ? 16'hFFFF : tot[15:0];
               prev_pix[i][c] = px[c];
            end
            KIND_BUILD: begin
               avg = round_quot(chan_sum[i][c], div_count);
               dif = round_quot(diff_sum[i][c], div_count);
               if (dif < 255)
                  dif = dif + 1;
               up = avg + high_mult * dif;
               dn = low_mult * dif;
               high_bnd[i][c] = (up > 255) ? 8'hFF : up[7:0];
               low_bnd[i][c] = (dn > avg) ? 8'h00 : 8'(avg - dn);
            end
            default: begin
               if (px[c] >= low_bnd[i][c] && px[c] <= high_bnd[i][c])
                  in_bnd = 1'b1;
            end
         endcase
      end
      if (r.kind == KIND_DETECT)
         o.foreground = !in_bnd;
      return o;
   endfunction

   task automatic note_mismatch(input string what, input rsp_type want, input rsp_type got);
      fail_count++;
      if (fail_count <= 10)
         $display("%0t: %s: expected fg=%b mask_valid=%b, got fg=%b mask_valid=%b",
                  $time, what, want.foreground, want.mask_valid, got.foreground,
                  got.mask_valid);
   endtask

   // monitor: tracks register writes, predicts on request transfers, checks responses
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         div_count = ACCUM_COUNT_RST;
         high_mult = HIGH_SCALE_RST;
         low_mult = LOW_SCALE_RST;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_ACCUM_COUNT: div_count = csr_data[CNT_W-1:0];
               CSR_HIGH_SCALE:  high_mult = csr_data[SCALE_W-1:0];
               CSR_LOW_SCALE:   low_mult = csr_data[SCALE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            expected_mask.push_back(update_pixel(req_data));
         if (rsp_valid && rsp_ready) begin
            rsp_count <= rsp_count + 1;
            if (expected_mask.size() == 0) begin
               note_mismatch("unexpected response", '0, rsp_data);
            end else begin
               want = expected_mask.pop_front();
               if (rsp_data.foreground !== want.foreground ||
                   rsp_data.mask_valid !== want.mask_valid)
                  note_mismatch("mask mismatch", want, rsp_data);
            end
         end
      end
   end

   // driver: bursts of transfers separated by random gaps
   int burst_left = 1;
   int gap_left = 0;
   always @(posedge clock) begin
      int unsigned roll;
      if (reset) begin
         req_valid <= 1'b0;
         burst_left <= $urandom_range(1, 48);
         gap_left <= 0;
      end else if (!req_valid || req_ready) begin
         if (gap_left != 0) begin
            req_valid <= 1'b0;
            gap_left <= gap_left - 1;
         end else if (pixel_queue.size() != 0) begin
            req_data <= pixel_queue.pop_front();
            req_valid <= 1'b1;
            if (burst_left <= 1) begin
               roll = $urandom_range(0, 9);
               burst_left <= $urandom_range(1, 48);
               gap_left <= (roll < 4) ? 0 : (roll < 8) ? $urandom_range(1, 4)
                                                      : $urandom_range(5, 25);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: stall pattern in segments, plus one long hold-off while traffic is offered
   int  seg_left = 0;
   int  seg_mode = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && rsp_count >= HOLD_AFTER && req_valid) begin
         rsp_ready <= 1'b0;
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         if (seg_left == 0) begin
            seg_mode <= $urandom_range(0, 3);
            seg_left <= $urandom_range(8, 80);
         end else begin
            seg_left <= seg_left - 1;
         end
         case (seg_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= ($urandom_range(0, 3) != 0);
            2: rsp_ready <= (seg_left % 3 != 0);
            default: rsp_ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // watchdog on cycles without any transfer
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("FAIL averaging_background_subtractor_unit");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] jitter(input int base, input int spread);
      int v;
      v = base + int'($urandom_range(0, 2 * spread)) - spread;
      return (v < 0) ? 8'd0 : (v > 255) ? 8'd255 : v[7:0];
   endfunction

   task automatic push_px(input kind_type k, input logic [15:0] idx,
                          input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
      req_type r;
      r.kind = k;
      r.pixel_index = idx;
      r.chan0 = a;
      r.chan1 = b;
      r.chan2 = c;
      pixel_queue.push_back(r);
   endtask

   function automatic logic [15:0] pick_spot();
      return ($urandom_range(0, 9) < 7) ? spots[$urandom_range(0, 9)] : 16'($urandom);
   endfunction

   // well-formed learn sequence: set previous, frames, build, then detects
   task automatic queue_scene(input logic [15:0] idx);
      int         frames, spread, b0, b1, b2;
      frames = $urandom_range(1, 12);
      spread = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      b0 = $urandom_range(0, 255);
      b1 = $urandom_range(0, 255);
      b2 = $urandom_range(0, 255);
      push_px(KIND_SET_PREV, idx, jitter(b0, spread), jitter(b1, spread), jitter(b2, spread));
      repeat (frames)
         push_px(KIND_ACCUM, idx, jitter(b0, spread), jitter(b1, spread),
                 jitter(b2, spread));
      push_px(KIND_BUILD, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      repeat ($urandom_range(1, 4)) begin
         if ($urandom_range(0, 1) != 0)
            push_px(KIND_DETECT, idx, jitter(b0, 3 * spread + 4), jitter(b1, 3 * spread + 4),
                    jitter(b2, 3 * spread + 4));
         else
            push_px(KIND_DETECT, idx, 8'($urandom), 8'($urandom), 8'($urandom));
      end
   endtask

   task automatic queue_noise();
      repeat ($urandom_range(1, 5))
         push_px(kind_type'($urandom_range(0, 3)), pick_spot(), 8'($urandom), 8'($urandom),
                 8'($urandom));
   endtask

   task automatic wait_idle();
      do
         @(negedge clock);
      while (pixel_queue.size() != 0 || req_valid || expected_mask.size() != 0);
   endtask

   task automatic write_regs(input logic [7:0] count, input logic [3:0] hi_mult,
                             input logic [3:0] lo_mult);
      logic [CSR_AW-1:0] idx [3];
      logic [CSR_DW-1:0] val [3];
      int                n;
      idx[0] = CSR_ACCUM_COUNT;
      idx[1] = CSR_HIGH_SCALE;
      idx[2] = CSR_LOW_SCALE;
      val[0] = count;
      val[1] = {4'($urandom), hi_mult};  // upper bits are don't-care
      val[2] = {4'($urandom), lo_mult};
      @(posedge clock);
      for (n = 0; n < 3; n++) begin
         csr_valid <= 1'b1;
         csr_index <= idx[n];
         csr_data <= val[n];
         @(posedge clock);
         while (!csr_ready)
            @(posedge clock);
      end
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [7:0] count, input logic [3:0] hi_mult,
                            input logic [3:0] lo_mult, input int target, input bit saturate);
      int n;
      wait_idle();
      write_regs(count, hi_mult, lo_mult);
      if (saturate) begin
         // constant 255 fills the channel sum, 0/255 toggling fills the difference sum
         push_px(KIND_SET_PREV, spots[2], 8'd0, 8'd0, 8'd0);
         for (n = 0; n < 260; n++)
            push_px(KIND_ACCUM, spots[2], 8'd255, (n % 2 == 0) ? 8'd255 : 8'd0, 8'($urandom));
         push_px(KIND_BUILD, spots[2], 8'd0, 8'd0, 8'd0);
         push_px(KIND_DETECT, spots[2], 8'd255, 8'd0, 8'd0);
         push_px(KIND_DETECT, spots[2], 8'd0, 8'd128, 8'd0);
      end
      while (pixel_queue.size() < target) begin
         if ($urandom_range(0, 4) != 0)
            queue_scene(pick_spot());
         else
            queue_noise();
      end
   endtask

   initial begin
      int ph;
      spots[0] = 16'h0000;
      spots[1] = 16'hFFFF;
      spots[2] = 16'($urandom);
      spots[3] = 16'h5A5A;
      spots[4] = 16'hA5A5;
      for (ph = 5; ph < 10; ph++)
         spots[ph] = 16'($urandom);

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed opening with reset configuration
      push_px(KIND_DETECT,   16'h0000, 8'd0,   8'd0,   8'd0);
      push_px(KIND_DETECT,   16'h0000, 8'd255, 8'd1,   8'd128);
      push_px(KIND_SET_PREV, 16'hFFFF, 8'd255, 8'd0,   8'd255);
      push_px(KIND_ACCUM,    16'hFFFF, 8'd0,   8'd255, 8'd0);
      push_px(KIND_ACCUM,    16'hFFFF, 8'd255, 8'd255, 8'd255);
      push_px(KIND_SET_PREV, 16'hFFFF, 8'd128, 8'd128, 8'd128);
      push_px(KIND_ACCUM,    16'hFFFF, 8'd128, 8'd127, 8'd129);
      push_px(KIND_BUILD,    16'hFFFF, 8'hAA,  8'h55,  8'hFF);
      push_px(KIND_DETECT,   16'hFFFF, 8'd0,   8'd0,   8'd0);
      push_px(KIND_DETECT,   16'hFFFF, 8'd255, 8'd255, 8'd255);
      push_px(KIND_DETECT,   16'hFFFF, 8'd200, 8'd200, 8'd200);
      // build on a never-trained pixel: zero sums
      push_px(KIND_BUILD,    16'h5A5A, 8'd0,   8'd0,   8'd0);
      push_px(KIND_DETECT,   16'h5A5A, 8'd7,   8'd8,   8'd8);
      push_px(KIND_DETECT,   16'h5A5A, 8'd8,   8'd8,   8'd8);
      // accumulate without a previous pixel
      push_px(KIND_ACCUM,    16'h5A5A, 8'd255, 8'd255, 8'd255);
      push_px(KIND_BUILD,    16'h5A5A, 8'd0,   8'd0,   8'd0);
      push_px(KIND_DETECT,   16'h5A5A, 8'd79,  8'd80,  8'd80);
      push_px(KIND_DETECT,   16'h5A5A, 8'd80,  8'd80,  8'd80);
      // quotients just either side of rounding
      push_px(KIND_SET_PREV, 16'hA5A5, 8'd0,   8'd0,   8'd0);
      push_px(KIND_ACCUM,    16'hA5A5, 8'd14,  8'd13,  8'd40);
      push_px(KIND_BUILD,    16'hA5A5, 8'd0,   8'd0,   8'd0);
      push_px(KIND_DETECT,   16'hA5A5, 8'd15,  8'd13,  8'd200);
      push_px(KIND_DETECT,   16'hA5A5, 8'd16,  8'd14,  8'd255);

      run_phase(8'd255, 4'd0,  4'd0,  160, 1'b1);
      run_phase(8'd1,   4'd15, 4'd15, 160, 1'b0);
      run_phase(8'd0,   4'd15, 4'd0,  160, 1'b0);
      run_phase(8'd2,   4'd3,  4'd2,  160, 1'b0);
      for (ph = 0; ph < 3; ph++)
         run_phase(($urandom_range(0, 9) < 7) ? 8'($urandom_range(1, 32)) : 8'($urandom),
                   4'($urandom), 4'($urandom), 160, 1'b0);

      wait_idle();
      repeat (30) @(negedge clock);
      if (fail_count == 0 && expected_mask.size() == 0)
         $display("PASS averaging_background_subtractor_unit");
      else
         $display("FAIL averaging_background_subtractor_unit");
      $finish;
   end

endmodule
